@@ hw/rtl/four_channel_feedback_delay_echo_top_macros.svh @@
// Assertion helpers for the feedback delay echo top level.
`ifndef FOUR_CHANNEL_FEEDBACK_DELAY_ECHO_TOP_MACROS_SVH
`define FOUR_CHANNEL_FEEDBACK_DELAY_ECHO_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fdn_echo_pkg.sv @@
package fdn_echo_pkg;

  localparam int FRAMES     = 32768;
  localparam int ADDR_W     = $clog2(FRAMES);
  localparam int LANES      = 4;
  localparam int SAMPLE_W   = 32;
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int NUM_REGS   = 7;
  localparam int CFG_DW     = 64;
  localparam int CFG_AW     = $clog2(NUM_REGS * 8);
  localparam int IDX_W      = CFG_AW - 3;
  localparam int FRAME_W    = LANES * SAMPLE_W;
  localparam int OBUF_DEPTH = 2;

  localparam logic signed [SAMPLE_W-1:0] Q31_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] Q31_MIN = 32'sh8000_0000;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic [DELAY_W-1:0]         delay_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DELAY  = 3'd0,
    REG_MIX_LO = 3'd1,
    REG_MIX_HI = 3'd2,
    REG_FB0    = 3'd3,
    REG_FB1    = 3'd4,
    REG_FB2    = 3'd5,
    REG_FB3    = 3'd6
  } reg_idx_t;

  localparam logic [CFG_DW-1:0] RST_DELAY  = 64'h6E00_3280_7700_3B80;
  localparam logic [CFG_DW-1:0] RST_MIX    = 64'h3FFF_FFFF_3FFF_FFFF;
  localparam logic [CFG_DW-1:0] RST_FB0    = 64'h0000_0000_0000_5FFF;
  localparam logic [CFG_DW-1:0] RST_FB1    = 64'h0000_0000_5FFF_0000;
  localparam logic [CFG_DW-1:0] RST_FB2    = 64'h0000_5FFF_0000_0000;
  localparam logic [CFG_DW-1:0] RST_FB3    = 64'h5FFF_0000_0000_0000;

  typedef struct packed {
    delay_t  [LANES-1:0]             delay;
    sample_t [LANES-1:0]             wet;
    gain_t   [LANES-1:0][LANES-1:0]  fb;     // fb[i][j]: echo j into channel i
  } cfg_t;

  typedef struct packed {
    logic  rd;
    logic  wr;
    logic  clr;
    logic  mul_en;
    addr_t wr_addr;
    addr_t wptr;
  } lane_ctl_t;

  function automatic sample_t sat_add(input sample_t a, input sample_t b);
    logic signed [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      return s[SAMPLE_W] ? Q31_MIN : Q31_MAX;
    end
    return s[SAMPLE_W-1:0];
  endfunction

  // Q31 by Q31, floor after the shift, no saturation.
  function automatic sample_t frac_mul(input sample_t a, input sample_t b);
    logic signed [2*SAMPLE_W-1:0] p;
    p = a * b;
    return p[2*SAMPLE_W-2:SAMPLE_W-1];
  endfunction

  // A Q15 gain stands for a Q31 value with its low half zero, so the
  // shift by 31 shrinks to a shift by 15 on the narrow product.
  function automatic sample_t frac_mul_gain(input sample_t a, input gain_t g);
    logic signed [SAMPLE_W+GAIN_W-1:0] p;
    p = a * g;
    return p[SAMPLE_W+GAIN_W-2:GAIN_W-1];
  endfunction

endpackage

@@ hw/rtl/four_channel_feedback_delay_echo_top.sv @@
// Four-channel feedback delay echo.
// The in_ stream carries one frame of four signed Q31 samples per request; the
// out_ stream returns one frame of four wet/dry mixed samples per request.
// Each channel has its own lane with a private delay store of 32768 samples, so
// all four echoes are read in one cycle and all four feedback words written in
// one cycle. A frame is read, multiplied, mixed and summed, and written back,
// in that order, and the next frame's read must follow that write, so no new
// frame is taken until the current one reaches its write-back. The mixed
// result is pushed into the output buffer at the mix step and waits there
// until the receiver takes it. After reset the stores are zeroed, one frame
// per cycle; in_tready stays low meanwhile, while register writes are taken.
// A two-entry output buffer lets the next frame be taken while a result
// waits; when the receiver holds out_tready low with two results pending,
// in_tready drops until one is taken. Registers sit at byte address 8*i on
// the 64-bit cfg_ port and should be written only while no frame is pending.
module four_channel_feedback_delay_echo_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // sample_zero [31:0], sample_one [63:32], sample_two [95:64],
  // sample_three [127:96]
  input  logic [fdn_echo_pkg::FRAME_W-1:0]  in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // mixed_zero [31:0], mixed_one [63:32], mixed_two [95:64],
  // mixed_three [127:96]
  output logic [fdn_echo_pkg::FRAME_W-1:0]  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fdn_echo_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [fdn_echo_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [fdn_echo_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import fdn_echo_pkg::*;

  localparam int CRED_W = $clog2(OBUF_DEPTH + 1);

  cfg_t                cfg;
  lane_ctl_t           lane_ctl;
  sample_t [LANES-1:0] x_r;
  sample_t [LANES-1:0] echo;
  sample_t [LANES-1:0] mixed;
  sample_t [LANES-1:0] wdata;
  logic [FRAME_W-1:0]  push_data;

  logic              clr_r, clr_nxt;
  addr_t             clr_addr_r, clr_addr_nxt;
  addr_t             wptr_r, wptr_nxt;
  logic              v_a_r, v_b_r, v_c_r, v_d_r;
  logic [CRED_W-1:0] cred_r, cred_nxt;
  logic              accept;
  logic              pop;

  assign cfg_pready = 1'b1;

  fdn_echo_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // Frames may not overlap in the read, multiply and mix stages: the next read has to
  // come after the current write-back.
  assign in_tready = !clr_r && !v_a_r && !v_b_r && !v_c_r
                     && (cred_r < CRED_W'(OBUF_DEPTH));
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    wptr_nxt     = wptr_r;
    cred_nxt     = cred_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(FRAMES - 1)) begin
        clr_nxt = 1'b0;
      end
    end
    if (v_d_r) begin
      wptr_nxt = (wptr_r == ADDR_W'(FRAMES - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (accept && !pop) begin
      cred_nxt = cred_r + 1'b1;
    end else if (pop && !accept) begin
      cred_nxt = cred_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      wptr_r     <= '0;
      v_a_r      <= 1'b0;
      v_b_r      <= 1'b0;
      v_c_r      <= 1'b0;
      v_d_r      <= 1'b0;
      cred_r     <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      wptr_r     <= wptr_nxt;
      v_a_r      <= accept;
      v_b_r      <= v_a_r;
      v_c_r      <= v_b_r;
      v_d_r      <= v_c_r;
      cred_r     <= cred_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < LANES; k++) begin
        x_r[k] <= in_tdata[SAMPLE_W*k +: SAMPLE_W];
      end
    end
  end

  always_comb begin
    lane_ctl.rd      = v_a_r;
    lane_ctl.wr      = v_d_r || clr_r;
    lane_ctl.clr     = clr_r;
    lane_ctl.mul_en  = v_b_r;
    lane_ctl.wr_addr = clr_r ? clr_addr_r : wptr_r;
    lane_ctl.wptr    = wptr_r;
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    fdn_echo_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .delay (cfg.delay[k]),
      .wet   (cfg.wet[k]),
      .x     (x_r[k]),
      .wdata (wdata[k]),
      .echo  (echo[k]),
      .mixed (mixed[k])
    );
  end

  fdn_echo_fb u_fb (
    .clk    (clk),
    .mul_en (v_b_r),
    .acc_en (v_c_r),
    .echo   (echo),
    .x      (x_r),
    .cfg    (cfg),
    .wdata  (wdata)
  );

  assign push_data = mixed;

  fdn_echo_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (v_c_r),
    .push_data  (push_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `include "four_channel_feedback_delay_echo_top_macros.svh"

  `FDE_ASSERT_NOW(a_port_excl, lane_ctl.rd, !lane_ctl.wr, "delay store read and write collide")
  `FDE_ASSERT_NOW(a_push_lat, v_c_r, $past(accept, 3), "result pushed without a matching request")
  `FDE_ASSERT_NEXT(a_cred_hold, accept, cred_r != '0, "accepted frame lost its output credit")
  `FDE_ASSERT_NOW(a_clr_quiet, clr_r, !v_a_r && !v_b_r && !v_c_r && !v_d_r, "frame in flight during clear")

endmodule

@@ hw/rtl/fdn_echo_regs.sv @@
module fdn_echo_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fdn_echo_pkg::CFG_AW-1:0]  paddr,
  input  logic [fdn_echo_pkg::CFG_DW-1:0]  pwdata,
  output logic [fdn_echo_pkg::CFG_DW-1:0]  prdata,
  output fdn_echo_pkg::cfg_t               cfg
);
  import fdn_echo_pkg::*;

  logic [CFG_DW-1:0] regs_r [NUM_REGS];
  reg_idx_t          idx;
  logic              hit;
  logic              wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign hit   = (idx <= REG_FB3);
  assign wr_en = psel && penable && pwrite && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_DELAY]  <= RST_DELAY;
      regs_r[REG_MIX_LO] <= RST_MIX;
      regs_r[REG_MIX_HI] <= RST_MIX;
      regs_r[REG_FB0]    <= RST_FB0;
      regs_r[REG_FB1]    <= RST_FB1;
      regs_r[REG_FB2]    <= RST_FB2;
      regs_r[REG_FB3]    <= RST_FB3;
    end else if (wr_en) begin
      regs_r[idx] <= pwdata;
    end
  end

  assign prdata = hit ? regs_r[idx] : '0;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      cfg.delay[k] = regs_r[REG_DELAY][DELAY_W*k +: DELAY_W];
      if (k < 2) begin
        cfg.wet[k] = regs_r[REG_MIX_LO][SAMPLE_W*(k%2) +: SAMPLE_W];
      end else begin
        cfg.wet[k] = regs_r[REG_MIX_HI][SAMPLE_W*(k%2) +: SAMPLE_W];
      end
      for (int j = 0; j < LANES; j++) begin
        cfg.fb[k][j] = regs_r[IDX_W'(int'(REG_FB0) + k)][GAIN_W*j +: GAIN_W];
      end
    end
  end

endmodule

@@ hw/rtl/fdn_echo_lane.sv @@
module fdn_echo_lane (
  input  logic                     clk,
  input  fdn_echo_pkg::lane_ctl_t  ctl,
  input  fdn_echo_pkg::delay_t     delay,
  input  fdn_echo_pkg::sample_t    wet,
  input  fdn_echo_pkg::sample_t    x,
  input  fdn_echo_pkg::sample_t    wdata,
  output fdn_echo_pkg::sample_t    echo,
  output fdn_echo_pkg::sample_t    mixed
);
  import fdn_echo_pkg::*;

  sample_t store_r [FRAMES];
  sample_t echo_r;
  sample_t wet_prod_r;
  sample_t dry_prod_r;
  sample_t dry;
  addr_t   rd_addr;

  // The delay is taken modulo the store depth; the subtraction wraps.
  assign rd_addr = ctl.wptr - delay[ADDR_W-1:0];

  // One port: the sequencer never reads and writes in the same cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      store_r[ctl.wr_addr] <= ctl.clr ? '0 : wdata;
    end
    if (ctl.rd) begin
      echo_r <= store_r[rd_addr];
    end
  end

  assign dry = wet[SAMPLE_W-1] ? Q31_MAX : Q31_MAX - wet;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      wet_prod_r <= frac_mul(wet, echo_r);
      dry_prod_r <= frac_mul(dry, x);
    end
  end

  assign echo  = echo_r;
  assign mixed = sat_add(wet_prod_r, dry_prod_r);

endmodule

@@ hw/rtl/fdn_echo_fb.sv @@
module fdn_echo_fb (
  input  logic                                          clk,
  input  logic                                          mul_en,
  input  logic                                          acc_en,
  input  fdn_echo_pkg::sample_t [fdn_echo_pkg::LANES-1:0] echo,
  input  fdn_echo_pkg::sample_t [fdn_echo_pkg::LANES-1:0] x,
  input  fdn_echo_pkg::cfg_t                            cfg,
  output fdn_echo_pkg::sample_t [fdn_echo_pkg::LANES-1:0] wdata
);
  import fdn_echo_pkg::*;

  sample_t [LANES-1:0][LANES-1:0] prod_r;
  sample_t [LANES-1:0]            acc_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int i = 0; i < LANES; i++) begin
        for (int j = 0; j < LANES; j++) begin
          prod_r[i][j] <= frac_mul_gain(echo[j], cfg.fb[i][j]);
        end
      end
    end
  end

  // The running sum saturates after every term, so the order of the terms
  // matters; the input and products 0 and 1 are summed into a register, and products 2 and 3 go in the next cycle.
  always_ff @(posedge clk) begin
    if (acc_en) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= sat_add(sat_add(x[i], prod_r[i][0]), prod_r[i][1]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      wdata[i] = sat_add(sat_add(acc_r[i], prod_r[i][2]), prod_r[i][3]);
    end
  end

endmodule

@@ hw/rtl/fdn_echo_obuf.sv @@
module fdn_echo_obuf (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [fdn_echo_pkg::FRAME_W-1:0]  push_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fdn_echo_pkg::FRAME_W-1:0]  out_tdata
);
  import fdn_echo_pkg::*;

  localparam int PTR_W = $clog2(OBUF_DEPTH);

  logic [FRAME_W-1:0]             ent_r [OBUF_DEPTH];
  logic [PTR_W-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [$clog2(OBUF_DEPTH+1)-1:0] cnt_r, cnt_nxt;
  logic                           pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(OBUF_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(OBUF_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
